// ===== rtl/core/ife_pkg.sv =====
// Shared types and constants of the infix expression evaluator.
`timescale 1ns / 1ps

package ife_pkg;

  localparam int unsigned VALUE_WIDTH_DEFAULT = 32;
  localparam int unsigned FIFO_DEPTH = 4;

  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_STAR  = 8'h2A;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  typedef enum logic [2:0] {
    CMD_DIGIT,
    CMD_SPACE,
    CMD_OTHER,
    CMD_ADD,
    CMD_SUB,
    CMD_MUL,
    CMD_DIV
  } cmd_e;

  typedef enum logic [1:0] {
    MOP_NONE,
    MOP_MUL,
    MOP_DIV
  } mop_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLOSE,
    ST_WAIT_DIV,
    ST_APPLY,
    ST_OUT
  } state_e;

  typedef struct packed {
    cmd_e       cmd;
    logic [3:0] digit;
    logic       last;
  } item_t;

endpackage

// ===== rtl/core/ife_front.sv =====
// Front end: accepts characters, classifies them and pushes commands into the queue.
`timescale 1ns / 1ps

module ife_front (
  input  logic             [7:0] char_code_i,
  input  logic             last_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             full_i,
  output logic             push_o,
  output ife_pkg::item_t   item_o
);

  ife_pkg::cmd_e cmd;
  logic [7:0]    digit_full;

  always_comb begin
    digit_full = char_code_i - ife_pkg::CHAR_ZERO;
    if (char_code_i >= ife_pkg::CHAR_ZERO && char_code_i <= ife_pkg::CHAR_NINE) begin
      cmd = ife_pkg::CMD_DIGIT;
    end else if (char_code_i == ife_pkg::CHAR_SPACE) begin
      cmd = ife_pkg::CMD_SPACE;
    end else if (char_code_i == ife_pkg::CHAR_PLUS) begin
      cmd = ife_pkg::CMD_ADD;
    end else if (char_code_i == ife_pkg::CHAR_MINUS) begin
      cmd = ife_pkg::CMD_SUB;
    end else if (char_code_i == ife_pkg::CHAR_STAR) begin
      cmd = ife_pkg::CMD_MUL;
    end else if (char_code_i == ife_pkg::CHAR_SLASH) begin
      cmd = ife_pkg::CMD_DIV;
    end else begin
      cmd = ife_pkg::CMD_OTHER;
    end
  end

  assign in_stall_o   = full_i;
  assign item_o.cmd   = cmd;
  assign item_o.digit = digit_full[3:0];
  assign item_o.last  = last_i;
  // A space that does not end the expression changes nothing and is dropped here.
  assign push_o = in_valid_i && !full_i && (cmd != ife_pkg::CMD_SPACE || last_i);

endmodule

// ===== rtl/core/ife_fifo.sv =====
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps

module ife_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ife_pkg::item_t item_i,
  input  logic           pop_i,
  output ife_pkg::item_t item_o,
  output logic           full_o,
  output logic           empty_o
);

  localparam int unsigned Depth = ife_pkg::FIFO_DEPTH;
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  ife_pkg::item_t mem_q [Depth];
  logic [AW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]  count_q, count_d;
  logic           do_push, do_pop;

  assign full_o  = (count_q == CW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ===== rtl/core/ife_div.sv =====
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
`timescale 1ns / 1ps

module ife_div #(
  parameter int unsigned VALUE_WIDTH = ife_pkg::VALUE_WIDTH_DEFAULT
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [VALUE_WIDTH-1:0] num_i,
  input  logic [VALUE_WIDTH-1:0] den_i,
  output logic                   done_o,
  output logic [VALUE_WIDTH-1:0] quot_o
);

  localparam int unsigned W  = VALUE_WIDTH;
  localparam int unsigned CW = $clog2(W);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [W-1:0]  rem_q, quo_q, den_q;
  logic          neg_q;
  logic [W:0]    rem_shift;
  logic [W:0]    trial;
  logic [W-1:0]  num_mag, den_mag;

  assign num_mag   = num_i[W-1] ? ({W{1'b0}} - num_i) : num_i;
  assign den_mag   = den_i[W-1] ? ({W{1'b0}} - den_i) : den_i;
  assign rem_shift = {rem_q, quo_q[W-1]};
  assign trial     = rem_shift - {1'b0, den_q};
  assign done_o    = done_q;
  assign quot_o    = neg_q ? ({W{1'b0}} - quo_q) : quo_q;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(W - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_mag;
      den_q <= den_mag;
      neg_q <= num_i[W-1] ^ den_i[W-1];
    end else if (busy_q) begin
      if (!trial[W]) begin
        rem_q <= trial[W-1:0];
        quo_q <= {quo_q[W-2:0], 1'b1};
      end else begin
        rem_q <= rem_shift[W-1:0];
        quo_q <= {quo_q[W-2:0], 1'b0};
      end
    end
  end

endmodule

// ===== rtl/core/ife_back.sv =====
// Back end: executes queued commands, folds operands and terms, drives the result.
`timescale 1ns / 1ps

module ife_back #(
  parameter int unsigned VALUE_WIDTH = ife_pkg::VALUE_WIDTH_DEFAULT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          empty_i,
  input  ife_pkg::item_t                item_i,
  output logic                          pop_o,
  output logic                          div_start_o,
  output logic [VALUE_WIDTH-1:0]        div_num_o,
  output logic [VALUE_WIDTH-1:0]        div_den_o,
  input  logic                          div_done_i,
  input  logic [VALUE_WIDTH-1:0]        div_quot_i,
  output logic signed [VALUE_WIDTH-1:0] value_o,
  output logic                          div_zero_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i
);

  localparam int unsigned W = VALUE_WIDTH;

  ife_pkg::state_e state_q, state_d;
  ife_pkg::cmd_e   cmd_q, cmd_d;
  ife_pkg::mop_e   mop_q, mop_d;
  logic            last_q, last_d;
  logic            fin_q, fin_d;
  logic [W-1:0]    sum_q, sum_d;
  logic [W-1:0]    term_q, term_d;
  logic [W-1:0]    cur_q, cur_d;
  logic            sign_q, sign_d;
  logic            in_num_q, in_num_d;
  logic            err_q, err_d;
  logic            out_valid_q, out_valid_d;
  logic            load_out;
  logic [W-1:0]    value_q;
  logic            div_zero_q;
  logic [W-1:0]    prod;
  logic [W-1:0]    digit_ext;
  logic [W-1:0]    cur_times_ten;

  assign prod          = term_q * cur_q;
  assign digit_ext     = W'(item_i.digit);
  assign cur_times_ten = (cur_q << 3) + (cur_q << 1);
  assign div_num_o     = term_q;
  assign div_den_o     = cur_q;
  assign value_o       = value_q;
  assign div_zero_o    = div_zero_q;
  assign out_valid_o   = out_valid_q;

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    mop_d       = mop_q;
    last_d      = last_q;
    fin_d       = fin_q;
    sum_d       = sum_q;
    term_d      = term_q;
    cur_d       = cur_q;
    sign_d      = sign_q;
    in_num_d    = in_num_q;
    err_d       = err_q;
    pop_o       = 1'b0;
    div_start_o = 1'b0;
    load_out    = 1'b0;
    unique case (state_q)
      ife_pkg::ST_IDLE: begin
        if (!empty_i) begin
          pop_o  = 1'b1;
          cmd_d  = item_i.cmd;
          last_d = item_i.last;
          fin_d  = 1'b0;
          unique case (item_i.cmd)
            ife_pkg::CMD_DIGIT: begin
              cur_d    = in_num_q ? cur_times_ten + digit_ext : digit_ext;
              in_num_d = 1'b1;
              if (item_i.last) begin
                fin_d   = 1'b1;
                state_d = ife_pkg::ST_CLOSE;
              end
            end
            ife_pkg::CMD_SPACE, ife_pkg::CMD_OTHER: begin
              in_num_d = (item_i.cmd == ife_pkg::CMD_SPACE) ? in_num_q : 1'b0;
              if (item_i.last) begin
                fin_d   = 1'b1;
                state_d = ife_pkg::ST_CLOSE;
              end
            end
            ife_pkg::CMD_ADD, ife_pkg::CMD_SUB, ife_pkg::CMD_MUL, ife_pkg::CMD_DIV: begin
              state_d = ife_pkg::ST_CLOSE;
            end
            default: begin
              state_d = ife_pkg::ST_IDLE;
            end
          endcase
        end
      end
      ife_pkg::ST_CLOSE: begin
        cur_d    = '0;
        in_num_d = 1'b0;
        unique case (mop_q)
          ife_pkg::MOP_MUL: begin
            term_d  = prod;
            state_d = ife_pkg::ST_APPLY;
          end
          ife_pkg::MOP_DIV: begin
            if (cur_q == '0) begin
              err_d   = 1'b1;
              term_d  = '0;
              state_d = ife_pkg::ST_APPLY;
            end else begin
              div_start_o = 1'b1;
              state_d     = ife_pkg::ST_WAIT_DIV;
            end
          end
          default: begin
            term_d  = cur_q;
            state_d = ife_pkg::ST_APPLY;
          end
        endcase
      end
      ife_pkg::ST_WAIT_DIV: begin
        if (div_done_i) begin
          term_d  = div_quot_i;
          state_d = ife_pkg::ST_APPLY;
        end
      end
      ife_pkg::ST_APPLY: begin
        if (fin_q) begin
          sum_d   = sign_q ? sum_q - term_q : sum_q + term_q;
          term_d  = '0;
          mop_d   = ife_pkg::MOP_NONE;
          state_d = ife_pkg::ST_OUT;
        end else begin
          unique case (cmd_q)
            ife_pkg::CMD_ADD, ife_pkg::CMD_SUB: begin
              sum_d  = sign_q ? sum_q - term_q : sum_q + term_q;
              term_d = '0;
              mop_d  = ife_pkg::MOP_NONE;
              sign_d = (cmd_q == ife_pkg::CMD_SUB);
            end
            ife_pkg::CMD_MUL: begin
              mop_d = ife_pkg::MOP_MUL;
            end
            ife_pkg::CMD_DIV: begin
              mop_d = ife_pkg::MOP_DIV;
            end
            default: begin
              mop_d = mop_q;
            end
          endcase
          if (last_q) begin
            fin_d   = 1'b1;
            state_d = ife_pkg::ST_CLOSE;
          end else begin
            state_d = ife_pkg::ST_IDLE;
          end
        end
      end
      ife_pkg::ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          sum_d    = '0;
          term_d   = '0;
          cur_d    = '0;
          sign_d   = 1'b0;
          mop_d    = ife_pkg::MOP_NONE;
          in_num_d = 1'b0;
          err_d    = 1'b0;
          fin_d    = 1'b0;
          state_d  = ife_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ife_pkg::ST_IDLE;
      end
    endcase
    out_valid_d = load_out || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ife_pkg::ST_IDLE;
      cmd_q       <= ife_pkg::CMD_SPACE;
      mop_q       <= ife_pkg::MOP_NONE;
      last_q      <= 1'b0;
      fin_q       <= 1'b0;
      sum_q       <= '0;
      term_q      <= '0;
      cur_q       <= '0;
      sign_q      <= 1'b0;
      in_num_q    <= 1'b0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cmd_q       <= cmd_d;
      mop_q       <= mop_d;
      last_q      <= last_d;
      fin_q       <= fin_d;
      sum_q       <= sum_d;
      term_q      <= term_d;
      cur_q       <= cur_d;
      sign_q      <= sign_d;
      in_num_q    <= in_num_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      value_q    <= err_q ? '0 : sum_q;
      div_zero_q <= err_q;
    end
  end

endmodule

// ===== rtl/core/infix_expression_evaluator_core.sv =====
// Top level of the infix expression evaluator: front end, command queue, back end, divider.
// A beat is queued and then popped by the back end; there a digit, space or other character
// is handled in the idle state, an operator passes through close and apply, and also through
// the divider wait when it closes a division. The last beat adds the final close and apply and
// the output state, which loads the output register unless a valid result is still stalled.
// Reset is asynchronous and active low; it empties the queue and clears all evaluation state.
`timescale 1ns / 1ps

module infix_expression_evaluator_core #(
  parameter int unsigned VALUE_WIDTH = ife_pkg::VALUE_WIDTH_DEFAULT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [7:0]                    char_code_i,
  input  logic                          last_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  output logic signed [VALUE_WIDTH-1:0] value_o,
  output logic                          div_zero_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i
);

  ife_pkg::item_t         push_item;
  ife_pkg::item_t         pop_item;
  logic                   push;
  logic                   pop;
  logic                   full;
  logic                   empty;
  logic                   div_start;
  logic                   div_done;
  logic [VALUE_WIDTH-1:0] div_num;
  logic [VALUE_WIDTH-1:0] div_den;
  logic [VALUE_WIDTH-1:0] div_quot;

  ife_front u_front (
    .char_code_i (char_code_i),
    .last_i      (last_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .full_i      (full),
    .push_o      (push),
    .item_o      (push_item)
  );

  ife_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .pop_i   (pop),
    .item_o  (pop_item),
    .full_o  (full),
    .empty_o (empty)
  );

  ife_div #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  ife_back #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .item_i      (pop_item),
    .pop_o       (pop),
    .div_start_o (div_start),
    .div_num_o   (div_num),
    .div_den_o   (div_den),
    .div_done_i  (div_done),
    .div_quot_i  (div_quot),
    .value_o     (value_o),
    .div_zero_o  (div_zero_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i)
  );

`ifndef SYNTHESIS
  a_pop_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !empty)
    else $error("Back end popped an empty command queue.");

  a_div_zero_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && div_zero_o) |-> (value_o == '0))
    else $error("Division by zero reported with a nonzero value.");

  a_div_not_instant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |=> (!div_done && !div_start))
    else $error("Divider finished or restarted right after a start.");
`endif

endmodule
